/* hw/rtl/contiguous_fit_allocator_assert.svh */
// Assertion macros for the allocator; clk and rst_n are taken from the scope of use.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_ASSERT_SVH

// Condition that must hold at every edge outside reset.
`define CFA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle forces a consequence in the next.
`define CFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/cfa_pkg.sv */
package cfa_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int ADDR_BITS_DEF  = 16;

    localparam int OP_W     = 2;
    localparam int PID_W    = 16;
    localparam int REQ_W    = 17;
    localparam int STAT_W   = 2;
    localparam int START_W  = 16;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_DATA_W-1:0] PART_SIZE_RESET = 17'h10000;

    // operations
    localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
    localparam logic [OP_W-1:0] OP_COALESCE = 2'd2;

    // result status
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_MEM   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_PROC  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // fit policies
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_ALIAS = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_SIZE  = 2'd1;

    // table passes run by the datapath
    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_NONE  = 4'd0;
    localparam logic [PH_W-1:0] PH_INIT  = 4'd1;
    localparam logic [PH_W-1:0] PH_FSCAN = 4'd2;
    localparam logic [PH_W-1:0] PH_FREM  = 4'd3;
    localparam logic [PH_W-1:0] PH_UINS  = 4'd4;
    localparam logic [PH_W-1:0] PH_FINS  = 4'd5;
    localparam logic [PH_W-1:0] PH_UREM  = 4'd6;
    localparam logic [PH_W-1:0] PH_SLOAD = 4'd7;
    localparam logic [PH_W-1:0] PH_SDOWN = 4'd8;
    localparam logic [PH_W-1:0] PH_MLOAD = 4'd9;
    localparam logic [PH_W-1:0] PH_MERGE = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [PID_W-1:0] process_id;
        logic [REQ_W-1:0] request_size;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [START_W-1:0] block_start;
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] used_count;
    } out_item_t;

    typedef struct packed {
        logic [PH_W-1:0] phase;
        logic            start;
        logic            oi_init;
    } cfa_cmd_t;

    typedef struct packed {
        logic            done;
        logic            found;
        logic            req_zero;
        logic            used_full;
        logic            free_full;
        logic            has_rem;
        logic            sort_more;
        logic            fcnt_zero;
        logic [OP_W-1:0] op;
    } cfa_sts_t;

endpackage

/* hw/rtl/contiguous_fit_allocator.sv */
// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid / in_ready   | in_item  (operation, process_id, request_size)
// out     | out | out_valid / out_ready | out_item (status, block_start, counts)
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request at a time. Allocate runs up to four table passes, free two, and coalesce
// an insertion sort plus a merge pass. After reset, and after each partition size
// write, one init pass rebuilds the tables before the next request is taken. The result
// waits in an output register; a stalled output lets one more request run, then holds
// it in the final state.
`include "contiguous_fit_allocator_assert.svh"

module contiguous_fit_allocator #(
    parameter int MAX_BLOCKS = cfa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = cfa_pkg::ADDR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cfa_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cfa_pkg::out_item_t             out_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cfa_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS+1);
    localparam int SW = ADDR_BITS + 1;
    localparam int CW = (SW > CFG_DATA_W) ? SW : CFG_DATA_W;

    // configuration
    logic [1:0]            fit_reg;
    logic [CFG_DATA_W-1:0] part_reg;
    logic                  init_pend_reg;
    logic                  cfg_wr, part_wr;
    logic [CW-1:0]         part_ext, part_lim, part_clip;
    logic [SW-1:0]         part_size;

    // result register
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic       out_free;

    cfa_cmd_t          cmd;
    cfa_sts_t          sts;
    logic              fin, init_ack;
    logic [STAT_W-1:0] stat;
    logic [ADDR_BITS-1:0] sel_first;
    logic [IW-1:0]     free_cnt, used_cnt;
    logic [START_W-1:0] block_start;
    logic              counts_ok;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign part_wr   = cfg_wr && (cfg_index == CFG_PART_SIZE);

    // partition clipped to the address space
    assign part_ext  = CW'(part_reg);
    assign part_lim  = CW'(1) << ADDR_BITS;
    assign part_clip = (part_ext > part_lim) ? part_lim : part_ext;
    assign part_size = part_clip[SW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_reg       <= POL_FIRST;
            part_reg      <= PART_SIZE_RESET;
            init_pend_reg <= 1'b1;
        end
        else
        begin
            if (cfg_wr && (cfg_index == CFG_FIT_POLICY))
            begin
                fit_reg <= cfg_data[1:0];
            end
            if (part_wr)
            begin
                part_reg <= cfg_data;
            end
            // a new write wins over a finishing rebuild
            if (part_wr)
            begin
                init_pend_reg <= 1'b1;
            end
            else if (init_ack)
            begin
                init_pend_reg <= 1'b0;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    cfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .init_req (init_pend_reg),
        .in_valid (in_valid),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready),
        .fin      (fin),
        .init_ack (init_ack),
        .stat     (stat)
    );

    cfa_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .item       (in_item),
        .item_load  (in_valid && in_ready),
        .fit_policy (fit_reg),
        .part_size  (part_size),
        .sel_first  (sel_first),
        .free_cnt   (free_cnt),
        .used_cnt   (used_cnt)
    );

    // start address only on a successful allocate
    assign block_start = ((stat == ST_OK) && (sts.op == OP_ALLOC)) ? START_W'(sel_first)
                                                                   : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            out_item_reg.status      <= stat;
            out_item_reg.block_start <= block_start;
            out_item_reg.free_count  <= COUNT_W'(free_cnt);
            out_item_reg.used_count  <= COUNT_W'(used_cnt);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign counts_ok = (free_cnt <= IW'(MAX_BLOCKS)) && (used_cnt <= IW'(MAX_BLOCKS));

    `CFA_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "request taken while busy")
    `CFA_ASSERT_ALWAYS(a_fin_slot, !fin || out_free, "result written over a pending one")
    `CFA_ASSERT_ALWAYS(a_count_range, counts_ok, "table count out of range")

endmodule

/* hw/rtl/cfa_dpath.sv */
module cfa_dpath #(
    parameter int MAX_BLOCKS = cfa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = cfa_pkg::ADDR_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cfa_pkg::cfa_cmd_t                cmd,
    output cfa_pkg::cfa_sts_t                sts,
    input  cfa_pkg::in_item_t                item,
    input  logic                             item_load,
    input  logic [1:0]                       fit_policy,
    input  logic [ADDR_BITS:0]               part_size,
    output logic [ADDR_BITS-1:0]             sel_first,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]  free_cnt,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]  used_cnt
);
    import cfa_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int AI = $clog2(MAX_BLOCKS);
    localparam int IW = $clog2(MAX_BLOCKS+1);
    localparam int SW = AW + 1;
    localparam int RW = (SW > REQ_W) ? SW : REQ_W;
    localparam int FW = 2 * AW;
    localparam int UW = 2 * AW + PID_W;

    // tables: free {first,last}, used {first,last,owner}
    logic [FW-1:0] free_mem_reg [MAX_BLOCKS];
    logic [UW-1:0] used_mem_reg [MAX_BLOCKS];
    logic [FW-1:0] f_rd_reg;
    logic [UW-1:0] u_rd_reg;

    logic          f_we, u_we;
    logic [AI-1:0] f_wa, u_wa, raddr;
    logic [FW-1:0] f_wd;
    logic [UW-1:0] u_wd;

    logic [OP_W-1:0]  op_reg;
    logic [PID_W-1:0] pid_reg;
    logic [REQ_W-1:0] req_reg;

    logic [IW-1:0] fcnt_reg, fcnt_next, ucnt_reg, ucnt_next;
    logic [IW-1:0] idx_reg, idx_next, n_reg, n_next, oi_reg, oi_next;
    logic          rv_reg, rv_next, stop_reg, stop_next;
    logic          found_reg, found_next, placed_reg, placed_next;
    logic [AI-1:0] dpos_reg, dpos_next, sel_reg, sel_next;
    logic [AW-1:0] sel_first_reg, sel_first_next, sel_last_reg, sel_last_next;
    logic [AW-1:0] hold_first_reg, hold_first_next, hold_last_reg, hold_last_next;
    logic [SW-1:0] best_reg, best_next, ksz_reg, ksz_next;
    logic [FW-1:0] carry_f_reg, carry_f_next;
    logic [UW-1:0] carry_u_reg, carry_u_next;

    logic [AW-1:0] rd_first, rd_last, urd_first, urd_last;
    logic [PID_W-1:0] urd_owner;
    logic [SW-1:0] rd_size, new_last_w, key_size;
    logic [AW-1:0] new_last, rem_first, key_first;
    logic [1:0]    pol;
    logic          fits, take, ins_cond, has_rem, free_full;
    logic          active, down, issue, tail, proc, stop_now;
    logic [IW-1:0] start_idx, end_idx;

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            free_mem_reg[f_wa] <= f_wd;
        end
        if (u_we)
        begin
            used_mem_reg[u_wa] <= u_wd;
        end
        f_rd_reg <= free_mem_reg[raddr];
        u_rd_reg <= used_mem_reg[raddr];
    end

    assign rd_first  = f_rd_reg[FW-1:AW];
    assign rd_last   = f_rd_reg[AW-1:0];
    assign urd_first = u_rd_reg[UW-1:AW+PID_W];
    assign urd_last  = u_rd_reg[AW+PID_W-1:PID_W];
    assign urd_owner = u_rd_reg[PID_W-1:0];
    assign rd_size   = {1'b0, rd_last} - {1'b0, rd_first} + SW'(1);

    assign pol        = (fit_policy == POL_ALIAS) ? POL_FIRST : fit_policy;
    assign fits       = RW'(rd_size) >= RW'(req_reg);
    assign new_last_w = {1'b0, sel_first_reg} + SW'(req_reg) - SW'(1);
    assign new_last   = new_last_w[AW-1:0];
    assign rem_first  = AW'(new_last_w + SW'(1));
    assign has_rem    = new_last_w < {1'b0, sel_last_reg};
    assign key_first  = (op_reg == OP_ALLOC) ? rem_first : sel_first_reg;
    assign key_size   = {1'b0, sel_last_reg} - {1'b0, key_first} + SW'(1);
    assign free_full  = fcnt_reg >= IW'(MAX_BLOCKS);

    always_comb
    begin
        case (pol)
            POL_BEST:  take = !found_reg || (rd_size < best_reg);
            POL_WORST: take = !found_reg || (rd_size > best_reg);
            default:   take = !found_reg;
        endcase
        case (pol)
            POL_BEST:  ins_cond = rd_size > ksz_reg;
            POL_WORST: ins_cond = rd_size < ksz_reg;
            default:   ins_cond = 1'b0;
        endcase
    end

    always_comb
    begin
        case (cmd.phase)
            PH_FREM:  start_idx = IW'(sel_reg) + IW'(1);
            PH_SLOAD: start_idx = oi_reg;
            PH_SDOWN: start_idx = oi_reg;
            PH_MERGE: start_idx = IW'(1);
            default:  start_idx = '0;
        endcase
        case (cmd.phase)
            PH_FSCAN: end_idx = fcnt_reg;
            PH_FREM:  end_idx = fcnt_reg;
            PH_FINS:  end_idx = fcnt_reg;
            PH_MERGE: end_idx = fcnt_reg;
            PH_UINS:  end_idx = ucnt_reg;
            PH_UREM:  end_idx = ucnt_reg;
            PH_SLOAD: end_idx = oi_reg + IW'(1);
            PH_MLOAD: end_idx = IW'(1);
            default:  end_idx = '0;
        endcase
    end

    // sort pass walks downward; every other pass walks upward
    assign active   = (cmd.phase != PH_NONE) && !cmd.start;
    assign down     = cmd.phase == PH_SDOWN;
    assign proc     = active && rv_reg;
    assign stop_now = proc && down && !stop_reg && !(rd_first > hold_first_reg);
    assign issue    = active && (down ? ((idx_reg != '0) && !stop_reg && !stop_now)
                                      : (idx_reg < end_idx));
    assign raddr    = down ? AI'(idx_reg - IW'(1)) : idx_reg[AI-1:0];
    assign tail     = active && !rv_reg &&
                      (down ? ((idx_reg == '0) || stop_reg) : (idx_reg >= end_idx));

    always_comb
    begin
        fcnt_next = fcnt_reg;    ucnt_next = ucnt_reg;
        idx_next = idx_reg;      n_next = n_reg;          oi_next = oi_reg;
        rv_next = issue;         stop_next = stop_reg;
        found_next = found_reg;  placed_next = placed_reg;
        dpos_next = raddr;       sel_next = sel_reg;
        sel_first_next = sel_first_reg;   sel_last_next = sel_last_reg;
        hold_first_next = hold_first_reg; hold_last_next = hold_last_reg;
        best_next = best_reg;    ksz_next = ksz_reg;
        carry_f_next = carry_f_reg;       carry_u_next = carry_u_reg;
        f_we = 1'b0; f_wa = '0; f_wd = '0;
        u_we = 1'b0; u_wa = '0; u_wd = '0;

        if (cmd.oi_init)
        begin
            oi_next = IW'(1);
        end

        if (cmd.start)
        begin
            idx_next    = start_idx;
            stop_next   = 1'b0;
            found_next  = 1'b0;
            placed_next = 1'b0;
            n_next      = IW'(1);
            carry_u_next = {sel_first_reg, new_last, pid_reg};
            carry_f_next = {key_first, sel_last_reg};
            ksz_next     = key_size;
        end

        if (issue)
        begin
            idx_next = down ? (idx_reg - IW'(1)) : (idx_reg + IW'(1));
        end

        if (stop_now)
        begin
            stop_next = 1'b1;
        end

        if (proc)
        begin
            case (cmd.phase)
                PH_FSCAN:
                begin
                    if (fits && take)
                    begin
                        found_next     = 1'b1;
                        sel_next       = dpos_reg;
                        sel_first_next = rd_first;
                        sel_last_next  = rd_last;
                        best_next      = rd_size;
                    end
                end
                PH_FREM:
                begin
                    f_we = 1'b1;
                    f_wa = dpos_reg - AI'(1);
                    f_wd = f_rd_reg;
                end
                PH_UINS:
                begin
                    if (placed_reg || (urd_first > sel_first_reg))
                    begin
                        u_we = 1'b1;
                        u_wa = dpos_reg;
                        u_wd = carry_u_reg;
                        carry_u_next = u_rd_reg;
                        placed_next  = 1'b1;
                    end
                end
                PH_FINS:
                begin
                    if (placed_reg || ins_cond)
                    begin
                        f_we = 1'b1;
                        f_wa = dpos_reg;
                        f_wd = carry_f_reg;
                        carry_f_next = f_rd_reg;
                        placed_next  = 1'b1;
                    end
                end
                PH_UREM:
                begin
                    if (found_reg)
                    begin
                        u_we = !free_full;
                        u_wa = dpos_reg - AI'(1);
                        u_wd = u_rd_reg;
                    end
                    else if (urd_owner == pid_reg)
                    begin
                        found_next     = 1'b1;
                        sel_first_next = urd_first;
                        sel_last_next  = urd_last;
                    end
                end
                PH_SLOAD, PH_MLOAD:
                begin
                    hold_first_next = rd_first;
                    hold_last_next  = rd_last;
                end
                PH_SDOWN:
                begin
                    if (!stop_reg)
                    begin
                        f_we = 1'b1;
                        f_wa = dpos_reg + AI'(1);
                        f_wd = stop_now ? {hold_first_reg, hold_last_reg} : f_rd_reg;
                    end
                end
                PH_MERGE:
                begin
                    if (({1'b0, hold_last_reg} + SW'(1)) == {1'b0, rd_first})
                    begin
                        hold_last_next = rd_last;
                    end
                    else
                    begin
                        f_we = 1'b1;
                        f_wa = AI'(n_reg - IW'(1));
                        f_wd = {hold_first_reg, hold_last_reg};
                        hold_first_next = rd_first;
                        hold_last_next  = rd_last;
                        n_next = n_reg + IW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (tail)
        begin
            case (cmd.phase)
                PH_INIT:
                begin
                    f_we = 1'b1;
                    f_wa = '0;
                    f_wd = {AW'(0), AW'(part_size - SW'(1))};
                    fcnt_next = (part_size != '0) ? IW'(1) : IW'(0);
                    ucnt_next = '0;
                end
                PH_FREM:
                begin
                    fcnt_next = fcnt_reg - IW'(1);
                end
                PH_UINS:
                begin
                    u_we = 1'b1;
                    u_wa = ucnt_reg[AI-1:0];
                    u_wd = carry_u_reg;
                    ucnt_next = ucnt_reg + IW'(1);
                end
                PH_FINS:
                begin
                    f_we = 1'b1;
                    f_wa = fcnt_reg[AI-1:0];
                    f_wd = carry_f_reg;
                    fcnt_next = fcnt_reg + IW'(1);
                end
                PH_UREM:
                begin
                    if (found_reg && !free_full)
                    begin
                        ucnt_next = ucnt_reg - IW'(1);
                    end
                end
                PH_SDOWN:
                begin
                    if (!stop_reg)
                    begin
                        f_we = 1'b1;
                        f_wa = '0;
                        f_wd = {hold_first_reg, hold_last_reg};
                    end
                    oi_next = oi_reg + IW'(1);
                end
                PH_MERGE:
                begin
                    f_we = 1'b1;
                    f_wa = AI'(n_reg - IW'(1));
                    f_wd = {hold_first_reg, hold_last_reg};
                    fcnt_next = n_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg   <= '0;
            ucnt_reg   <= '0;
            idx_reg    <= '0;
            n_reg      <= '0;
            oi_reg     <= '0;
            rv_reg     <= 1'b0;
            stop_reg   <= 1'b0;
            found_reg  <= 1'b0;
            placed_reg <= 1'b0;
        end
        else
        begin
            fcnt_reg   <= fcnt_next;
            ucnt_reg   <= ucnt_next;
            idx_reg    <= idx_next;
            n_reg      <= n_next;
            oi_reg     <= oi_next;
            rv_reg     <= rv_next;
            stop_reg   <= stop_next;
            found_reg  <= found_next;
            placed_reg <= placed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            op_reg  <= item.operation;
            pid_reg <= item.process_id;
            req_reg <= item.request_size;
        end
        dpos_reg       <= dpos_next;
        sel_reg        <= sel_next;
        sel_first_reg  <= sel_first_next;
        sel_last_reg   <= sel_last_next;
        hold_first_reg <= hold_first_next;
        hold_last_reg  <= hold_last_next;
        best_reg       <= best_next;
        ksz_reg        <= ksz_next;
        carry_f_reg    <= carry_f_next;
        carry_u_reg    <= carry_u_next;
    end

    assign sts.done      = tail;
    assign sts.found     = found_reg;
    assign sts.req_zero  = req_reg == '0;
    assign sts.used_full = ucnt_reg >= IW'(MAX_BLOCKS);
    assign sts.free_full = free_full;
    assign sts.has_rem   = has_rem;
    assign sts.sort_more = oi_reg < fcnt_reg;
    assign sts.fcnt_zero = fcnt_reg == '0;
    assign sts.op        = op_reg;

    assign sel_first = sel_first_reg;
    assign free_cnt  = fcnt_reg;
    assign used_cnt  = ucnt_reg;

endmodule

/* hw/rtl/cfa_ctrl.sv */
module cfa_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       init_req,
    input  logic                       in_valid,
    input  logic                       out_free,
    input  cfa_pkg::cfa_sts_t          sts,
    output cfa_pkg::cfa_cmd_t          cmd,
    output logic                       in_ready,
    output logic                       fin,
    output logic                       init_ack,
    output logic [cfa_pkg::STAT_W-1:0] stat
);
    import cfa_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_FSCAN = 4'd3;
    localparam logic [3:0] S_FREM  = 4'd4;
    localparam logic [3:0] S_UINS  = 4'd5;
    localparam logic [3:0] S_FINS  = 4'd6;
    localparam logic [3:0] S_UREM  = 4'd7;
    localparam logic [3:0] S_SCHK  = 4'd8;
    localparam logic [3:0] S_SLOAD = 4'd9;
    localparam logic [3:0] S_SDOWN = 4'd10;
    localparam logic [3:0] S_MLOAD = 4'd11;
    localparam logic [3:0] S_MERGE = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic              run_reg, run_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [PH_W-1:0]   ph;
    logic              ph_done;

    always_comb
    begin
        case (state_reg)
            S_INIT:  ph = PH_INIT;
            S_FSCAN: ph = PH_FSCAN;
            S_FREM:  ph = PH_FREM;
            S_UINS:  ph = PH_UINS;
            S_FINS:  ph = PH_FINS;
            S_UREM:  ph = PH_UREM;
            S_SLOAD: ph = PH_SLOAD;
            S_SDOWN: ph = PH_SDOWN;
            S_MLOAD: ph = PH_MLOAD;
            S_MERGE: ph = PH_MERGE;
            default: ph = PH_NONE;
        endcase
    end

    // first cycle of a pass loads the pointers, then wait for its tail
    assign ph_done = run_reg && sts.done;

    always_comb
    begin
        state_next  = state_reg;
        stat_next   = stat_reg;
        run_next    = 1'b0;
        cmd.phase   = ph;
        cmd.start   = (ph != PH_NONE) && !run_reg;
        cmd.oi_init = 1'b0;
        in_ready    = 1'b0;
        fin         = 1'b0;
        init_ack    = 1'b0;

        if (ph != PH_NONE)
        begin
            run_next = !ph_done;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (init_req)
                begin
                    state_next = S_INIT;
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        state_next = S_DISP;
                    end
                end
            end
            S_INIT:
            begin
                if (ph_done)
                begin
                    init_ack   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DISP:
            begin
                stat_next  = ST_OK;
                state_next = S_FIN;
                case (sts.op)
                    OP_ALLOC:
                    begin
                        if (sts.req_zero)
                        begin
                            stat_next = ST_NO_MEM;
                        end
                        else if (sts.used_full)
                        begin
                            stat_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_FSCAN;
                        end
                    end
                    OP_FREE:
                    begin
                        state_next = S_UREM;
                    end
                    OP_COALESCE:
                    begin
                        cmd.oi_init = 1'b1;
                        state_next  = S_SCHK;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FSCAN:
            begin
                if (ph_done)
                begin
                    if (sts.found)
                    begin
                        state_next = S_FREM;
                    end
                    else
                    begin
                        stat_next  = ST_NO_MEM;
                        state_next = S_FIN;
                    end
                end
            end
            S_FREM:
            begin
                if (ph_done)
                begin
                    state_next = S_UINS;
                end
            end
            S_UINS:
            begin
                if (ph_done)
                begin
                    state_next = sts.has_rem ? S_FINS : S_FIN;
                end
            end
            S_FINS:
            begin
                if (ph_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_UREM:
            begin
                if (ph_done)
                begin
                    if (!sts.found)
                    begin
                        stat_next  = ST_NO_PROC;
                        state_next = S_FIN;
                    end
                    else if (sts.free_full)
                    begin
                        stat_next  = ST_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_FINS;
                    end
                end
            end
            S_SCHK:
            begin
                if (sts.sort_more)
                begin
                    state_next = S_SLOAD;
                end
                else if (sts.fcnt_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_MLOAD;
                end
            end
            S_SLOAD:
            begin
                if (ph_done)
                begin
                    state_next = S_SDOWN;
                end
            end
            S_SDOWN:
            begin
                if (ph_done)
                begin
                    state_next = S_SCHK;
                end
            end
            S_MLOAD:
            begin
                if (ph_done)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                if (ph_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= 1'b0;
            stat_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            stat_reg  <= stat_next;
        end
    end

    assign stat = stat_reg;

endmodule
